// File: sv/accel_limited_velocity_command_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the limited velocity command block
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ACCEL_LIMITED_VELOCITY_COMMAND_MACROS_SVH
`define ACCEL_LIMITED_VELOCITY_COMMAND_MACROS_SVH

`ifndef ASSERT_OFF
`define ALVC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALVC_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ALVC_ASSERT(label, clk, rst_n, prop, msg)
`define ALVC_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: sv/alvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited velocity command package
// Field widths, register map and reset values shared by the block.
// ----------------------------------------------------------------------------
package alvc_pkg;

	localparam int DIST_W  = 16;
	localparam int BEAR_W  = 16;
	localparam int DT_W    = 16;
	localparam int CMD_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int ACC_W   = 16;
	localparam int SPEED_W = 15;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// Targets: linear reaches 2^24 in magnitude, angular 2^18
	localparam int TGT_W   = 26;
	// Step bound: (accel * dt) >> 12
	localparam int BOUND_W = 20;

	// pi/2 in Q3.13, floor of 12867.96
	localparam logic [BEAR_W:0] HALF_PI_Q13 = 17'd12867;

	typedef enum logic [IDX_W-1:0] {
		REG_LIN_GAIN  = 3'd0,
		REG_ANG_GAIN  = 3'd1,
		REG_LIN_ACCEL = 3'd2,
		REG_ANG_ACCEL = 3'd3,
		REG_LIN_SPEED = 3'd4,
		REG_ANG_SPEED = 3'd5
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0]  LIN_GAIN_RST  = 16'd410;
	localparam logic [GAIN_W-1:0]  ANG_GAIN_RST  = 16'd2048;
	localparam logic [ACC_W-1:0]   LIN_ACCEL_RST = 16'd410;
	localparam logic [ACC_W-1:0]   ANG_ACCEL_RST = 16'd2048;
	localparam logic [SPEED_W-1:0] LIN_SPEED_RST = 15'd4096;
	localparam logic [SPEED_W-1:0] ANG_SPEED_RST = 15'd6431;

endpackage

// File: sv/alvc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Obstacle request channel
// Valid/ready channel carrying distance, bearing and elapsed time.
// ----------------------------------------------------------------------------
interface alvc_in_if
	import alvc_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [DIST_W-1:0]        obstacle_distance;
	logic signed [BEAR_W-1:0] obstacle_bearing;
	logic [DT_W-1:0]          elapsed_time;

	modport source (output valid, output obstacle_distance, output obstacle_bearing,
		output elapsed_time, input ready);
	modport sink (input valid, input obstacle_distance, input obstacle_bearing,
		input elapsed_time, output ready);
endinterface

// File: sv/alvc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command channel
// Valid/ready channel carrying the limited linear and angular commands.
// ----------------------------------------------------------------------------
interface alvc_out_if
	import alvc_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] linear_command;
	logic signed [CMD_W-1:0] angular_command;

	modport source (output valid, output linear_command, output angular_command,
		input ready);
	modport sink (input valid, input linear_command, input angular_command,
		output ready);
endinterface

// File: sv/alvc_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew and speed limiter
// Moves the previous command toward the target by at most the step bound,
// then clamps the result to the symmetric speed limit.
// ----------------------------------------------------------------------------
module alvc_limiter
	import alvc_pkg::*;
(
	input  logic signed [TGT_W-1:0] target,
	input  logic signed [CMD_W-1:0] prev,
	input  logic [BOUND_W-1:0]      bound,
	input  logic [SPEED_W-1:0]      speed,
	output logic signed [CMD_W-1:0] cmd
);

	localparam int WIDE_W = TGT_W + 2;

	function automatic logic signed [WIDE_W-1:0] clamp_sym(
		input logic signed [WIDE_W-1:0] v,
		input logic signed [WIDE_W-1:0] b
	);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (v > b) begin
			r = b;
		end else if (v < -b) begin
			r = -b;
		end
		return r;
	endfunction

	logic signed [WIDE_W-1:0] prev_w;
	logic signed [WIDE_W-1:0] diff;
	logic signed [WIDE_W-1:0] step;
	logic signed [WIDE_W-1:0] nxt;
	logic signed [WIDE_W-1:0] lim;

	always_comb begin
		prev_w = WIDE_W'(prev);
		diff   = WIDE_W'(target) - prev_w;
		step   = clamp_sym(diff, $signed(WIDE_W'(bound)));
		nxt    = prev_w + step;
		lim    = clamp_sym(nxt, $signed(WIDE_W'(speed)));
		cmd    = lim[CMD_W-1:0];
	end

endmodule

// File: sv/accel_limited_velocity_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited velocity command
// Three-stage pipeline: input register, product register, output register.
// Each request passes through the three registers in turn; one request
// is accepted every cycle while the output is taken. The previous command
// closes its loop through the output register, which sets the rate; a full
// output that is not taken stalls the stages behind it; empty ones still fill.
// ----------------------------------------------------------------------------
`include "accel_limited_velocity_command_macros.svh"

module accel_limited_velocity_command
	import alvc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	alvc_in_if.sink           item,
	alvc_out_if.source        result
);

	logic [GAIN_W-1:0]  lin_gain_q;
	logic [GAIN_W-1:0]  ang_gain_q;
	logic [ACC_W-1:0]   lin_acc_q;
	logic [ACC_W-1:0]   ang_acc_q;
	logic [SPEED_W-1:0] lin_spd_q;
	logic [SPEED_W-1:0] ang_spd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= LIN_GAIN_RST;
			ang_gain_q <= ANG_GAIN_RST;
			lin_acc_q  <= LIN_ACCEL_RST;
			ang_acc_q  <= ANG_ACCEL_RST;
			lin_spd_q  <= LIN_SPEED_RST;
			ang_spd_q  <= ANG_SPEED_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_LIN_GAIN:  lin_gain_q <= cfg_wdata;
				REG_ANG_GAIN:  ang_gain_q <= cfg_wdata;
				REG_LIN_ACCEL: lin_acc_q  <= cfg_wdata;
				REG_ANG_ACCEL: ang_acc_q  <= cfg_wdata;
				REG_LIN_SPEED: lin_spd_q  <= cfg_wdata[SPEED_W-1:0];
				REG_ANG_SPEED: ang_spd_q  <= cfg_wdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake
	logic v_s1, v_s2, v_s3;
	logic load_s1, load_s2, load_s3;

	assign load_s3    = v_s2 && (!v_s3 || result.ready);
	assign load_s2    = v_s1 && (!v_s2 || load_s3);
	assign item.ready = !v_s1 || load_s2;
	assign load_s1    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (item.ready) begin
				v_s1 <= item.valid;
			end
			if (!v_s2 || load_s3) begin
				v_s2 <= v_s1;
			end
			if (!v_s3 || result.ready) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: request register
	logic [DIST_W-1:0]        dist_s1;
	logic signed [BEAR_W-1:0] bear_s1;
	logic [DT_W-1:0]          dt_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			dist_s1 <= item.obstacle_distance;
			bear_s1 <= item.obstacle_bearing;
			dt_s1   <= item.elapsed_time;
		end
	end

	// Rear obstacle fold and products
	logic signed [BEAR_W:0]              bear_w;
	logic signed [BEAR_W:0]              bear_mag;
	logic                                rear;
	logic signed [BEAR_W:0]              bear_f;
	logic signed [DIST_W+1:0]            dist_f;
	logic signed [GAIN_W+DIST_W+2:0]     lin_prod;
	logic signed [GAIN_W+BEAR_W+1:0]     ang_prod;
	logic [ACC_W+DT_W-1:0]               lin_bprod;
	logic [ACC_W+DT_W-1:0]               ang_bprod;

	always_comb begin
		bear_w   = (BEAR_W+1)'(bear_s1);
		bear_mag = bear_w[BEAR_W] ? -bear_w : bear_w;
		rear     = $unsigned(bear_mag) > HALF_PI_Q13;
		bear_f   = rear ? -bear_w : bear_w;
		// Linear target drives away: sign is minus distance unless folded
		dist_f   = rear ? $signed((DIST_W+2)'(dist_s1)) : -$signed((DIST_W+2)'(dist_s1));
		lin_prod = $signed((GAIN_W+1)'(lin_gain_q)) * dist_f;
		ang_prod = $signed((GAIN_W+1)'(ang_gain_q)) * bear_f;
		lin_bprod = (ACC_W+DT_W)'(lin_acc_q) * (ACC_W+DT_W)'(dt_s1);
		ang_bprod = (ACC_W+DT_W)'(ang_acc_q) * (ACC_W+DT_W)'(dt_s1);
	end

	// Stage 2: targets and step bounds
	logic signed [TGT_W-1:0] lin_tgt_s2, ang_tgt_s2;
	logic [BOUND_W-1:0]      lin_bnd_s2, ang_bnd_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			lin_tgt_s2 <= TGT_W'(lin_prod >>> 8);
			ang_tgt_s2 <= TGT_W'(ang_prod >>> 13);
			lin_bnd_s2 <= BOUND_W'(lin_bprod >> 12);
			ang_bnd_s2 <= BOUND_W'(ang_bprod >> 12);
		end
	end

	// Stage 3: output register, also the previous command
	logic signed [CMD_W-1:0] lin_s3, ang_s3;
	logic signed [CMD_W-1:0] lin_nxt, ang_nxt;

	alvc_limiter u_lin_lim (
		.target (lin_tgt_s2),
		.prev   (lin_s3),
		.bound  (lin_bnd_s2),
		.speed  (lin_spd_q),
		.cmd    (lin_nxt)
	);

	alvc_limiter u_ang_lim (
		.target (ang_tgt_s2),
		.prev   (ang_s3),
		.bound  (ang_bnd_s2),
		.speed  (ang_spd_q),
		.cmd    (ang_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_s3 <= '0;
			ang_s3 <= '0;
		end else if (load_s3) begin
			lin_s3 <= lin_nxt;
			ang_s3 <= ang_nxt;
		end
	end

	assign result.valid           = v_s3;
	assign result.linear_command  = lin_s3;
	assign result.angular_command = ang_s3;

	logic signed [CMD_W-1:0] lin_lim, ang_lim;
	logic                    lin_over, ang_over;
	logic [2*CMD_W-1:0]      cmd_s3;
	logic                    pipe_empty;

	assign lin_lim    = $signed(CMD_W'(lin_spd_q));
	assign ang_lim    = $signed(CMD_W'(ang_spd_q));
	assign lin_over   = v_s3 && (lin_s3 > lin_lim || lin_s3 < -lin_lim);
	assign ang_over   = v_s3 && (ang_s3 > ang_lim || ang_s3 < -ang_lim);
	assign cmd_s3     = {lin_s3, ang_s3};
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	`ALVC_NEVER(a_lin_speed, clk, arst_n, lin_over, "linear command beyond speed limit")
	`ALVC_NEVER(a_ang_speed, clk, arst_n, ang_over, "angular command beyond speed limit")
	`ALVC_ASSERT(a_state_hold, clk, arst_n, !load_s3 |=> $stable(cmd_s3), "command moved unloaded")
	`ALVC_ASSERT(a_empty_ready, clk, arst_n, pipe_empty |-> item.ready, "empty pipeline refuses a request")

endmodule

// File: tb/sv/tb_accel_limited_velocity_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited velocity command testbench
// Sends obstacle requests through the valid/ready channel. Each accepted
// request goes to a scoreboard that predicts the slew- and speed-limited
// linear and angular commands. Each accepted command is checked in order
// against those predictions. The run starts with directed corner requests,
// then steps through several register settings with random requests,
// random source gaps and random sink stalls, except in one quiet phase.
// ----------------------------------------------------------------------------
module tb_accel_limited_velocity_command;
	import alvc_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 125;
	localparam int NUM_PHASES   = 8;
	localparam int QUIET_PHASE  = 4;
	localparam int MAX_REPORTS  = 10;
	localparam int BEAR_MAX     = 25736;
	localparam int HALF_PI_INT  = 12867;

	localparam logic [IDX_W-1:0] REG_NONE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_NONE_HI = 3'd7;

	typedef struct packed {
		logic signed [CMD_W-1:0] lin;
		logic signed [CMD_W-1:0] ang;
	} command_t;

	class command_scoreboard;
		logic [GAIN_W-1:0]  lin_gain;
		logic [GAIN_W-1:0]  ang_gain;
		logic [ACC_W-1:0]   lin_accel;
		logic [ACC_W-1:0]   ang_accel;
		logic [SPEED_W-1:0] lin_speed;
		logic [SPEED_W-1:0] ang_speed;
		longint             prev_lin;
		longint             prev_ang;
		command_t           pending_commands[$];
		int                 mismatches;
		int                 checked;

		function new();
			lin_gain   = LIN_GAIN_RST;
			ang_gain   = ANG_GAIN_RST;
			lin_accel  = LIN_ACCEL_RST;
			ang_accel  = ANG_ACCEL_RST;
			lin_speed  = LIN_SPEED_RST;
			ang_speed  = ANG_SPEED_RST;
			prev_lin   = 0;
			prev_ang   = 0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_LIN_GAIN:  lin_gain  = value;
				REG_ANG_GAIN:  ang_gain  = value;
				REG_LIN_ACCEL: lin_accel = value;
				REG_ANG_ACCEL: ang_accel = value;
				REG_LIN_SPEED: lin_speed = value[SPEED_W-1:0];
				REG_ANG_SPEED: ang_speed = value[SPEED_W-1:0];
				default: ;
			endcase
		endfunction

		function longint slew_limit(longint target, longint prev, longint accel,
				longint dt, longint speed);
			longint bound;
			longint step;
			longint nxt;
			bound = (accel * dt) >>> 12;
			step = target - prev;
			if (step > bound)
				step = bound;
			else if (step < -bound)
				step = -bound;
			nxt = prev + step;
			if (nxt > speed)
				nxt = speed;
			else if (nxt < -speed)
				nxt = -speed;
			return nxt;
		endfunction

		function void note_request(logic [DIST_W-1:0] distance,
				logic signed [BEAR_W-1:0] bearing, logic [DT_W-1:0] dt);
			longint   d;
			longint   b;
			longint   mag;
			longint   lin_target;
			longint   ang_target;
			command_t cmd;
			d = longint'(distance);
			b = longint'(bearing);
			mag = (b < 0) ? -b : b;
			if (mag > HALF_PI_INT) begin
				d = -d;
				b = -b;
			end
			lin_target = (-(longint'(lin_gain) * d)) >>> 8;
			ang_target = (longint'(ang_gain) * b) >>> 13;
			prev_lin = slew_limit(lin_target, prev_lin, longint'(lin_accel),
				longint'(dt), longint'(lin_speed));
			prev_ang = slew_limit(ang_target, prev_ang, longint'(ang_accel),
				longint'(dt), longint'(ang_speed));
			cmd.lin = prev_lin[CMD_W-1:0];
			cmd.ang = prev_ang[CMD_W-1:0];
			pending_commands = {pending_commands, cmd};
		endfunction

		function void check_result(logic signed [CMD_W-1:0] lin,
				logic signed [CMD_W-1:0] ang);
			command_t want;
			checked++;
			if (pending_commands.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected command: linear %0d angular %0d", lin, ang);
				return;
			end
			want = pending_commands.pop_front();
			if (lin !== want.lin || ang !== want.ang) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("command %0d: expected linear %0d angular %0d, got linear %0d angular %0d",
						checked, want.lin, want.ang, lin, ang);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;
	bit                quiet;
	int                cycle_count;
	int                requests_sent;
	int                settings_used;

	command_scoreboard sb;

	alvc_in_if  req_if ();
	alvc_out_if cmd_if ();

	accel_limited_velocity_command uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (req_if),
		.result    (cmd_if)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk)
		cmd_if.ready <= quiet || ($urandom_range(99) >= 24);

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				sb.check_result(cmd_if.linear_command, cmd_if.angular_command);
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.obstacle_distance, req_if.obstacle_bearing,
					req_if.elapsed_time);
		end
	end

	task automatic send_request(input logic [DIST_W-1:0] distance,
			input logic signed [BEAR_W-1:0] bearing, input logic [DT_W-1:0] dt);
		while (!quiet && $urandom_range(99) < 24) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid             <= 1'b1;
		req_if.obstacle_distance <= distance;
		req_if.obstacle_bearing  <= bearing;
		req_if.elapsed_time      <= dt;
		do
			@(posedge clk);
		while (!req_if.ready);
		requests_sent++;
	endtask

	task automatic drain_commands();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_commands.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_registers(input logic [CFG_W-1:0] vals [6]);
		for (int i = 0; i < 6; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.write_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_wen   <= 1'b1;
		cfg_index <= $urandom_range(1) ? REG_NONE_LO : REG_NONE_HI;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic signed [BEAR_W-1:0] pick_bearing();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return BEAR_W'($urandom);
		if (r == 1)
			return BEAR_W'(($urandom_range(1) ? 1 : -1) *
				(HALF_PI_INT - 2 + int'($urandom_range(4))));
		return BEAR_W'(int'($urandom_range(2 * BEAR_MAX)) - BEAR_MAX);
	endfunction

	function automatic logic [DT_W-1:0] pick_dt();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r <= 2)
			return DT_W'($urandom);
		return DT_W'($urandom_range(1024));
	endfunction

	function automatic logic [DIST_W-1:0] pick_distance();
		if ($urandom_range(3) == 0)
			return DIST_W'($urandom_range(512));
		return DIST_W'($urandom);
	endfunction

	initial begin
		logic [DIST_W-1:0]        dir_dist [20];
		logic signed [BEAR_W-1:0] dir_bear [20];
		logic [DT_W-1:0]          dir_dt   [20];
		logic [CFG_W-1:0]         setting  [6];

		sb            = new();
		quiet         = 1'b0;
		requests_sent = 0;
		settings_used = 0;

		arst_n                   = 1'b0;
		cfg_wen                  = 1'b0;
		cfg_index                = REG_LIN_GAIN;
		cfg_wdata                = '0;
		req_if.valid             = 1'b0;
		req_if.obstacle_distance = '0;
		req_if.obstacle_bearing  = '0;
		req_if.elapsed_time      = '0;

		dir_dist = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd256, 16'd256, 16'd256,
			16'd256, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd0, 16'hFFFF, 16'd12345,
			16'hFFFF, 16'd128, 16'hAAAA, 16'h5555, 16'hFFFF, 16'd1};
		dir_bear = '{16'sd0, 16'sd0, 16'sd25736, -16'sd25736, 16'sd12867,
			16'sd12868, -16'sd12867, -16'sd12868, 16'sh8000, 16'sd32767,
			16'sd8192, 16'sd0, 16'sd25736, -16'sd25736, -16'sd25736, 16'sd100,
			16'sh5555, 16'shAAAA, 16'sd0, 16'sd1};
		dir_dt = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096, 16'd4096,
			16'd4096, 16'd4096, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1,
			16'hFFFF, 16'hFFFF, 16'd410, 16'h5555, 16'hAAAA, 16'hFFFF, 16'd1};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_dist[i])
			send_request(dir_dist[i], dir_bear[i], dir_dt[i]);
		drain_commands();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				1: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				2: setting = '{16'd410, 16'd2048, 16'd0, 16'd0, 16'd4096, 16'd6431};
				3: setting = '{16'd410, 16'd2048, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
				4: setting = '{LIN_GAIN_RST, ANG_GAIN_RST, LIN_ACCEL_RST, ANG_ACCEL_RST,
					CFG_W'(LIN_SPEED_RST), CFG_W'(ANG_SPEED_RST)};
				default: foreach (setting[i]) setting[i] = CFG_W'($urandom);
			endcase
			program_registers(setting);
			quiet = (p == QUIET_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_distance(), pick_bearing(), pick_dt());
			drain_commands();
			quiet = 1'b0;
		end

		$display("sent %0d requests, checked %0d commands across %0d register settings",
			requests_sent, sb.checked, settings_used);
		$display("directed corners, rear bearings, zero and full limits, random gaps and stalls");
		if (sb.mismatches == 0 && sb.pending_commands.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d commands missing", sb.mismatches,
				sb.pending_commands.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: accel_limited_velocity_command.f
+incdir+sv
sv/alvc_pkg.sv
sv/alvc_in_if.sv
sv/alvc_out_if.sv
sv/alvc_limiter.sv
sv/accel_limited_velocity_command.sv
tb/sv/tb_accel_limited_velocity_command.sv
